// ===== rtl/i2c_bitbang_gpio_sequencer_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef I2C_BITBANG_GPIO_SEQUENCER_ASSERT_SVH
`define I2C_BITBANG_GPIO_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define I2CBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define I2CBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CBB_ASSERT_NOW(label, clk, rst, ante, cons, msg)

`define I2CBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/i2cbb_pkg.sv =====
package i2cbb_pkg;

  localparam int PIN_COUNT = 32;
  localparam logic [31:0] PORT_MASK = 32'((64'd1 << PIN_COUNT) - 64'd1);
  localparam logic [4:0] HALF_BIT_TICKS = 5'd20;
  localparam logic [4:0] SCL_FALLBACK_PIN = 5'd0;
  localparam logic [4:0] SDA_FALLBACK_PIN = 5'd1;
  localparam logic [2:0] LOOP_INIT = 3'd7;

  typedef enum logic [2:0] {
    REQ_INIT      = 3'd0,
    REQ_START     = 3'd1,
    REQ_STOP      = 3'd2,
    REQ_WRITE     = 3'd3,
    REQ_READ      = 3'd4,
    REQ_LOAD_OUT  = 3'd5,
    REQ_LOAD_DIR  = 3'd6,
    REQ_RESERVED  = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    OP_WR_OUT  = 3'd0,
    OP_WR_DIR  = 3'd1,
    OP_SAMPLE  = 3'd2,
    OP_ACK     = 3'd3,
    OP_DELAY   = 3'd4,
    OP_ENABLE  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CFG_CLOCK_PIN = 2'd0,
    CFG_DATA_PIN  = 2'd1,
    CFG_SLOW_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ACT_ENABLE,
    ACT_BOTH_HIGH,
    ACT_SCL_HIGH,
    ACT_SCL_LOW,
    ACT_SDA_HIGH,
    ACT_SDA_LOW,
    ACT_SDA_BIT,
    ACT_SDA_FIN,
    ACT_DIR_SCL_OUT,
    ACT_DIR_SDA_OUT,
    ACT_DIR_SDA_IN,
    ACT_DELAY,
    ACT_SAMPLE,
    ACT_ACK
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef logic [5:0] upc_t;

  // One microcode step. last_fast marks the final emitting step when
  // only half-bit delays follow it.
  typedef struct packed {
    act_t act;
    logic done;
    logic last_fast;
    logic loop;
    upc_t target;
  } ucode_t;

  typedef struct packed {
    logic fire;
    act_t act;
    logic level;
    logic last;
  } step_t;

  typedef struct packed {
    logic out_we;
    logic dir_we;
    logic [31:0] word;
  } preset_t;

  localparam upc_t UPC_INIT  = 6'd0;
  localparam upc_t UPC_START = 6'd5;
  localparam upc_t UPC_STOP  = 6'd11;
  localparam upc_t UPC_WRITE = 6'd17;
  localparam upc_t UPC_READ  = 6'd30;
  localparam upc_t UPC_READ_LOOP = 6'd31;

  function automatic ucode_t uc(act_t act, logic done, logic last_fast, logic loop,
                                upc_t target);
    ucode_t w;
    w.act = act;
    w.done = done;
    w.last_fast = last_fast;
    w.loop = loop;
    w.target = target;
    return w;
  endfunction

  function automatic upc_t ucode_entry(req_t req);
    upc_t e;
    case (req)
      REQ_INIT:  e = UPC_INIT;
      REQ_START: e = UPC_START;
      REQ_STOP:  e = UPC_STOP;
      REQ_WRITE: e = UPC_WRITE;
      REQ_READ:  e = UPC_READ;
      default:   e = UPC_INIT;
    endcase
    return e;
  endfunction

  function automatic ucode_t ucode_word(upc_t pc);
    ucode_t w;
    case (pc)
      // Init
      6'd0:  w = uc(ACT_ENABLE,      1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd1:  w = uc(ACT_ENABLE,      1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd2:  w = uc(ACT_BOTH_HIGH,   1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd3:  w = uc(ACT_DIR_SCL_OUT, 1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd4:  w = uc(ACT_DIR_SDA_OUT, 1'b1, 1'b0, 1'b0, UPC_INIT);
      // Start
      6'd5:  w = uc(ACT_BOTH_HIGH,   1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd6:  w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd7:  w = uc(ACT_SDA_LOW,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd8:  w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd9:  w = uc(ACT_SCL_LOW,     1'b0, 1'b1, 1'b0, UPC_INIT);
      6'd10: w = uc(ACT_DELAY,       1'b1, 1'b0, 1'b0, UPC_INIT);
      // Stop
      6'd11: w = uc(ACT_SDA_LOW,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd12: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd13: w = uc(ACT_SCL_HIGH,    1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd14: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd15: w = uc(ACT_SDA_HIGH,    1'b0, 1'b1, 1'b0, UPC_INIT);
      6'd16: w = uc(ACT_DELAY,       1'b1, 1'b0, 1'b0, UPC_INIT);
      // Write byte: bit loop, then the ack slot
      6'd17: w = uc(ACT_SDA_BIT,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd18: w = uc(ACT_SCL_HIGH,    1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd19: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd20: w = uc(ACT_SCL_LOW,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd21: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b1, UPC_WRITE);
      6'd22: w = uc(ACT_DIR_SDA_IN,  1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd23: w = uc(ACT_SDA_LOW,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd24: w = uc(ACT_SCL_HIGH,    1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd25: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd26: w = uc(ACT_ACK,         1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd27: w = uc(ACT_SCL_LOW,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd28: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd29: w = uc(ACT_DIR_SDA_OUT, 1'b1, 1'b0, 1'b0, UPC_INIT);
      // Read byte: sample loop, then ack or nack
      6'd30: w = uc(ACT_DIR_SDA_IN,  1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd31: w = uc(ACT_SCL_HIGH,    1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd32: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd33: w = uc(ACT_SAMPLE,      1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd34: w = uc(ACT_SCL_LOW,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd35: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b1, UPC_READ_LOOP);
      6'd36: w = uc(ACT_SDA_FIN,     1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd37: w = uc(ACT_DIR_SDA_OUT, 1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd38: w = uc(ACT_SCL_HIGH,    1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd39: w = uc(ACT_DELAY,       1'b0, 1'b0, 1'b0, UPC_INIT);
      6'd40: w = uc(ACT_SCL_LOW,     1'b0, 1'b1, 1'b0, UPC_INIT);
      6'd41: w = uc(ACT_DELAY,       1'b1, 1'b0, 1'b0, UPC_INIT);
      default: w = uc(ACT_DELAY,     1'b1, 1'b0, 1'b0, UPC_INIT);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/i2cbb_req_if.sv =====
interface i2cbb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  tx_byte;
  logic        final_read;
  logic [31:0] preset_word;

  modport source(output valid, req_type, tx_byte, final_read, preset_word, input ready);
  modport sink(input valid, req_type, tx_byte, final_read, preset_word, output ready);
endinterface

// ===== rtl/i2cbb_op_if.sv =====
interface i2cbb_op_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op_kind;
  logic [31:0] pin_word;
  logic [4:0]  delay_ticks;
  logic        last;

  modport source(output valid, op_kind, pin_word, delay_ticks, last, input ready);
  modport sink(input valid, op_kind, pin_word, delay_ticks, last, output ready);
endinterface

// ===== rtl/i2cbb_cfg_if.sv =====
interface i2cbb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/i2c_bitbang_gpio_sequencer.sv =====
// Channel  Role    Payload
// req      sink    req_type, tx_byte, final_read, preset_word
// op       source  op_kind, pin_word, delay_ticks, last
// cfg      sink    index, data (always ready)
//
// A command is taken only while no run is in progress.
// Init takes 5 steps, start and stop 6, write byte 48 and read byte 47.
// Delay steps still pass through the step counter in fast mode, where they emit nothing.
// Load commands update their word in the accepting cycle and emit nothing.
// Reset clears the words and returns the config registers to their reset values; a stalled op holds
// the step counter, except at delay steps in fast mode.
module i2c_bitbang_gpio_sequencer (
  input  logic       clk,
  input  logic       rst,
  i2cbb_req_if.sink  req,
  i2cbb_op_if.source op,
  i2cbb_cfg_if.sink  cfg
);
  import i2cbb_pkg::*;

  `include "i2c_bitbang_gpio_sequencer_assert.svh"

  logic [4:0] clock_pin;
  logic [4:0] data_pin;
  logic       slow_mode;
  logic       busy;
  logic       slot_free;
  logic       accept;
  logic       start;
  req_t       req_kind;
  step_t      step;
  preset_t    preset;

  assign req_kind = req_t'(req.req_type);
  assign req.ready = !busy;
  assign accept = req.valid && req.ready;
  assign start = accept && (req_kind inside {REQ_INIT, REQ_START, REQ_STOP, REQ_WRITE,
                                             REQ_READ});
  assign preset.out_we = accept && (req_kind == REQ_LOAD_OUT);
  assign preset.dir_we = accept && (req_kind == REQ_LOAD_DIR);
  assign preset.word = req.preset_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_pin <= 5'd0;
      data_pin <= 5'd1;
      slow_mode <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_CLOCK_PIN: clock_pin <= cfg.data;
        CFG_DATA_PIN:  data_pin <= cfg.data;
        CFG_SLOW_MODE: slow_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  i2cbb_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req_kind),
    .tx_byte    (req.tx_byte),
    .final_read (req.final_read),
    .slow_mode  (slow_mode),
    .slot_free  (slot_free),
    .busy       (busy),
    .step       (step)
  );

  i2cbb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .clock_pin (clock_pin),
    .data_pin  (data_pin),
    .step      (step),
    .preset    (preset),
    .slot_free (slot_free),
    .op        (op)
  );

  `I2CBB_ASSERT_NOW(a_fire_needs_slot, clk, rst, step.fire, slot_free, "op fired into a full slot")
  `I2CBB_ASSERT_NEXT(a_last_then_quiet, clk, rst, step.fire && step.last, !step.fire, "op emitted after last")
  `I2CBB_ASSERT_NOW(a_delay_ticks, clk, rst, op.valid && (op.op_kind == OP_DELAY), (op.delay_ticks == HALF_BIT_TICKS) && (op.pin_word == 32'd0), "bad delay op")

endmodule

// ===== rtl/i2cbb_sequencer.sv =====
module i2cbb_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  i2cbb_pkg::req_t     req,
  input  logic [7:0]          tx_byte,
  input  logic                final_read,
  input  logic                slow_mode,
  input  logic                slot_free,
  output logic                busy,
  output i2cbb_pkg::step_t    step
);
  import i2cbb_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  upc_t       pc;
  logic [2:0] loop_cnt;
  logic [7:0] shift;
  logic       fin;
  ucode_t     cw;
  logic       skip;
  logic       advance;

  assign cw = ucode_word(pc);

  // In fast mode a delay step emits nothing and only moves the step counter.
  always_comb begin
    skip = (cw.act == ACT_DELAY) && !slow_mode;
    busy = (state == ST_RUN);
    advance = busy && (skip || slot_free);
    step.fire = busy && slot_free && !skip;
    step.act = cw.act;
    step.level = (cw.act == ACT_SDA_BIT) ? shift[7] : fin;
    step.last = cw.done || (cw.last_fast && !slow_mode);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance && cw.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UPC_INIT;
      loop_cnt <= LOOP_INIT;
    end else if (start) begin
      pc <= ucode_entry(req);
      loop_cnt <= LOOP_INIT;
    end else if (advance) begin
      if (cw.loop && (loop_cnt != 3'd0)) begin
        pc <= cw.target;
        loop_cnt <= loop_cnt - 3'd1;
      end else begin
        pc <= pc + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= tx_byte;
      fin <= final_read;
    end else if (advance && (cw.act == ACT_SDA_BIT)) begin
      shift <= {shift[6:0], 1'b0};
    end
  end

endmodule

// ===== rtl/i2cbb_datapath.sv =====
module i2cbb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [4:0]          clock_pin,
  input  logic [4:0]          data_pin,
  input  i2cbb_pkg::step_t    step,
  input  i2cbb_pkg::preset_t  preset,
  output logic                slot_free,
  i2cbb_op_if.source          op
);
  import i2cbb_pkg::*;

  logic [31:0] output_word;
  logic [31:0] direction_word;
  logic [31:0] out_next;
  logic [31:0] dir_next;
  logic [31:0] scl_mask;
  logic [31:0] sda_mask;
  logic [4:0]  scl_pin;
  logic [4:0]  sda_pin;
  op_t         kind;
  logic [31:0] word;
  logic [4:0]  ticks;
  logic        valid;

  // Pins outside the port fall back to their default positions.
  always_comb begin
    scl_pin = ({1'b0, clock_pin} < 6'(PIN_COUNT)) ? clock_pin : SCL_FALLBACK_PIN;
    sda_pin = ({1'b0, data_pin} < 6'(PIN_COUNT)) ? data_pin : SDA_FALLBACK_PIN;
    scl_mask = 32'd1 << scl_pin;
    sda_mask = 32'd1 << sda_pin;
  end

  always_comb begin
    out_next = output_word;
    dir_next = direction_word;
    kind = OP_WR_OUT;
    ticks = 5'd0;
    case (step.act)
      ACT_ENABLE:      kind = OP_ENABLE;
      ACT_BOTH_HIGH:   out_next = output_word | scl_mask | sda_mask;
      ACT_SCL_HIGH:    out_next = output_word | scl_mask;
      ACT_SCL_LOW:     out_next = output_word & ~scl_mask;
      ACT_SDA_HIGH:    out_next = output_word | sda_mask;
      ACT_SDA_LOW:     out_next = output_word & ~sda_mask;
      ACT_SDA_BIT, ACT_SDA_FIN: begin
        out_next = step.level ? (output_word | sda_mask) : (output_word & ~sda_mask);
      end
      ACT_DIR_SCL_OUT: begin
        kind = OP_WR_DIR;
        dir_next = direction_word | scl_mask;
      end
      ACT_DIR_SDA_OUT: begin
        kind = OP_WR_DIR;
        dir_next = direction_word | sda_mask;
      end
      ACT_DIR_SDA_IN: begin
        kind = OP_WR_DIR;
        dir_next = direction_word & ~sda_mask;
      end
      ACT_DELAY: begin
        kind = OP_DELAY;
        ticks = HALF_BIT_TICKS;
      end
      ACT_SAMPLE:      kind = OP_SAMPLE;
      ACT_ACK:         kind = OP_ACK;
      default:         kind = OP_ENABLE;
    endcase
    case (kind)
      OP_WR_OUT: word = out_next;
      OP_WR_DIR: word = dir_next;
      default:   word = 32'd0;
    endcase
  end

  assign slot_free = !valid || op.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_word <= 32'd0;
      direction_word <= 32'd0;
    end else if (preset.out_we) begin
      output_word <= preset.word & PORT_MASK;
    end else if (preset.dir_we) begin
      direction_word <= preset.word & PORT_MASK;
    end else if (step.fire) begin
      output_word <= out_next;
      direction_word <= dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step.fire) begin
      valid <= 1'b1;
    end else if (op.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      op.op_kind <= kind;
      op.pin_word <= word;
      op.delay_ticks <= ticks;
      op.last <= step.last;
    end
  end

  assign op.valid = valid;

endmodule
